>>> sv/wbps_pkg.sv
`timescale 1ns / 1ps
// Package for the wildcard byte pattern search core.
// Holds sizes, register indexes and shared types; no dependencies.
package wbps_pkg;

  // Pattern and window sizes
  localparam int PAT_BYTES   = 16;
  localparam int WIN_DEPTH   = PAT_BYTES - 1;
  localparam int LEN_BITS    = 5;
  localparam int LENM1_BITS  = 4;
  localparam int OFFSET_BITS = 32;
  localparam int ADDR_BITS   = 64;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_BASE_ADDRESS = 3'd4
  } cfg_reg_t;

  typedef logic [7:0] byte_t;
  typedef logic [WIN_DEPTH-1:0][7:0] window_t;

  // Compare result handed from the match unit to the top level
  typedef struct packed {
    logic                  hit;
    logic [LENM1_BITS-1:0] len_m1;
  } match_res_t;

endpackage

>>> sv/wbps_match.sv
`timescale 1ns / 1ps
// Masked window compare for the wildcard byte pattern search core.
// Depends on wbps_pkg.
module wbps_match import wbps_pkg::*; (
  input  byte_t                  cur_byte,
  input  window_t                window,
  input  logic [63:0]            pattern_low,
  input  logic [63:0]            pattern_high,
  input  logic [PAT_BYTES-1:0]   care_mask,
  input  logic [LEN_BITS-1:0]    pattern_length,
  input  logic [OFFSET_BITS-1:0] bytes_seen,
  output match_res_t             res
);

  logic [LENM1_BITS-1:0] len_m1;
  byte_t                 cand [PAT_BYTES];
  byte_t                 pat  [PAT_BYTES];
  logic [PAT_BYTES-1:0]  byte_ok;
  logic                  window_full;
  logic                  not_saturated;

  // Effective length minus one: zero acts as one, above the cap acts as the cap
  always_comb begin
    if (pattern_length == '0) begin
      len_m1 = '0;
    end else if (pattern_length > LEN_BITS'(PAT_BYTES)) begin
      len_m1 = LENM1_BITS'(PAT_BYTES - 1);
    end else begin
      len_m1 = LENM1_BITS'(pattern_length - LEN_BITS'(1));
    end
  end

  // Candidate bytes by distance: the current byte, then the window newest first
  always_comb begin
    cand[0] = cur_byte;
    for (int j = 1; j < PAT_BYTES; j++) begin
      cand[j] = window[j-1];
    end
  end

  // Per-position compare; positions past the length and wildcards pass
  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      pat[k] = (k < 8) ? pattern_low[8*(k%8) +: 8] : pattern_high[8*(k%8) +: 8];
      if (LENM1_BITS'(k) > len_m1 || !care_mask[k]) begin
        byte_ok[k] = 1'b1;
      end else begin
        byte_ok[k] = (cand[len_m1 - LENM1_BITS'(k)] == pat[k]);
      end
    end
  end

  assign window_full   = (bytes_seen >= OFFSET_BITS'(len_m1));
  assign not_saturated = (bytes_seen != '1);

  assign res.hit    = window_full && not_saturated && (&byte_ok);
  assign res.len_m1 = len_m1;

endmodule

>>> sv/wildcard_byte_pattern_search_core.sv
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern search core: config registers,
// byte window, counters and the result register. Depends on wbps_pkg, wbps_match.
//
//   channel  ports                                       role
//   in       in_valid in_stall in_data_byte in_last_byte one image byte per item
//   out      out_valid out_stall out_found               one result per
//            out_match_address                           image
//   cfg      cfg_write_en cfg_index cfg_write_data       register writes
//
// One item is taken per cycle while the input is not stalled; the compare and
// address add sit between the input ports and the result register, so a result
// appears in the cycle after its byte. Reset (rst_n low, synchronous) clears the
// window, counters and result valid and loads register defaults. The input
// stalls only while a result is held and the output is stalled.
module wildcard_byte_pattern_search_core import wbps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [ADDR_BITS-1:0]      out_match_address,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_write_data
);

  logic [63:0]            pattern_low_r;
  logic [63:0]            pattern_high_r;
  logic [PAT_BYTES-1:0]   care_mask_r;
  logic [LEN_BITS-1:0]    pattern_length_r;
  logic [ADDR_BITS-1:0]   base_address_r;

  window_t                window_r, window_nxt;
  logic [OFFSET_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic                   reported_r, reported_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [ADDR_BITS-1:0]   out_addr_r, out_addr_nxt;

  match_res_t             mres;
  logic                   accept;
  logic                   hit;
  logic [OFFSET_BITS-1:0] offset;

  // Handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      care_mask_r      <= '0;
      pattern_length_r <= LEN_BITS'(1);
      base_address_r   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low_r    <= cfg_write_data;
        REG_PATTERN_HIGH: pattern_high_r   <= cfg_write_data;
        REG_CARE_MASK:    care_mask_r      <= cfg_write_data[PAT_BYTES-1:0];
        REG_PATTERN_LEN:  pattern_length_r <= cfg_write_data[LEN_BITS-1:0];
        REG_BASE_ADDRESS: base_address_r   <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // Window compare
  wbps_match u_match (
    .cur_byte       (in_data_byte),
    .window         (window_r),
    .pattern_low    (pattern_low_r),
    .pattern_high   (pattern_high_r),
    .care_mask      (care_mask_r),
    .pattern_length (pattern_length_r),
    .bytes_seen     (bytes_seen_r),
    .res            (mres)
  );

  assign hit    = mres.hit && !reported_r;
  assign offset = bytes_seen_r - OFFSET_BITS'(mres.len_m1);

  // Scan state: shift the window, count bytes, rearm on the last byte
  always_comb begin
    window_nxt     = window_r;
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (accept) begin
      if (in_last_byte) begin
        window_nxt     = '0;
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
      end else begin
        window_nxt = {window_r[WIN_DEPTH-2:0], in_data_byte};
        if (bytes_seen_r != '1) begin
          bytes_seen_nxt = bytes_seen_r + OFFSET_BITS'(1);
        end
        if (hit) begin
          reported_nxt = 1'b1;
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && hit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = 1'b1;
      out_addr_nxt  = base_address_r + ADDR_BITS'(offset);
    end else if (accept && in_last_byte && !reported_r) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = 1'b0;
      out_addr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

>>> tb/byte_scan_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard byte pattern search core: follows register writes,
// predicts the result of every image and checks the result channel.
// Depends on wbps_pkg.
module byte_scan_checker import wbps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_found,
  input  logic [ADDR_BITS-1:0]      out_match_address,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_write_data,
  output int                        fail_count,
  output int                        pending,
  output int                        results_checked,
  output int                        hits_checked
);

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] addr;
  } scan_result_t;

  // Shadow registers
  logic [63:0]            pat_lo;
  logic [63:0]            pat_hi;
  logic [15:0]            care;
  logic [LEN_BITS-1:0]    len_code;
  logic [ADDR_BITS-1:0]   base;

  // Scan state
  window_t                window;
  logic [OFFSET_BITS-1:0] seen;
  logic                   reported;

  scan_result_t scan_results_due[$];
  int mismatches = 0;
  int checked = 0;
  int hits = 0;

  function automatic byte_t pattern_byte(int k);
    logic [127:0] pat;
    pat = {pat_hi, pat_lo};
    return pat[8*k +: 8];
  endfunction

  // One image byte: window compare, then shift or rearm
  task automatic scan_byte(input byte_t cur, input logic last);
    int           len;
    logic         hit;
    byte_t        b;
    scan_result_t r;
    len = (len_code == 0) ? 1 : ((len_code > PAT_BYTES) ? PAT_BYTES : int'(len_code));
    hit = 1'b0;
    if (!reported && seen != '1 && seen >= OFFSET_BITS'(len - 1)) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        b = (k == len - 1) ? cur : window[len - 2 - k];
        if (care[k] && b != pattern_byte(k)) hit = 1'b0;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.addr  = base + ADDR_BITS'(seen) - ADDR_BITS'(len - 1);
      scan_results_due = {scan_results_due, r};
      reported = 1'b1;
    end else if (last && !reported) begin
      r.found = 1'b0;
      r.addr  = '0;
      scan_results_due = {scan_results_due, r};
    end
    if (last) begin
      window   = '0;
      seen     = '0;
      reported = 1'b0;
    end else begin
      window = {window[WIN_DEPTH-2:0], cur};
      if (seen != '1) seen++;
    end
  endtask

  task automatic check_result(input logic found, input logic [ADDR_BITS-1:0] addr);
    scan_result_t want;
    if (scan_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: found=%0b addr=%h", $realtime, found, addr);
    end else begin
      want = scan_results_due.pop_front();
      checked++;
      if (want.found) hits++;
      if (want.found !== found || want.addr !== addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                   $realtime, want.found, want.addr, found, addr);
      end
    end
  endtask

  // Results go first: a result never belongs to the item taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pat_lo   = '0;
      pat_hi   = '0;
      care     = '0;
      len_code = LEN_BITS'(1);
      base     = '0;
      window   = '0;
      seen     = '0;
      reported = 1'b0;
      scan_results_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_found, out_match_address);
      if (in_valid && !in_stall) scan_byte(in_data_byte, in_last_byte);
      if (cfg_write_en) begin
        case (cfg_index)
          REG_PATTERN_LOW:  pat_lo   = cfg_write_data;
          REG_PATTERN_HIGH: pat_hi   = cfg_write_data;
          REG_CARE_MASK:    care     = cfg_write_data[15:0];
          REG_PATTERN_LEN:  len_code = cfg_write_data[LEN_BITS-1:0];
          REG_BASE_ADDRESS: base     = cfg_write_data;
          default: ;
        endcase
      end
    end
    fail_count      <= mismatches;
    pending         <= scan_results_due.size();
    results_checked <= checked;
    hits_checked    <= hits;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for the wildcard byte pattern search core: clock, reset,
// image stimulus and verdict. Depends on wbps_pkg, the core, byte_scan_checker.
module testbench;
  import wbps_pkg::*;

  localparam int SPARE_FIRST = int'(REG_BASE_ADDRESS) + 1;
  localparam int SPARE_LAST  = (1 << CFG_INDEX_BITS) - 1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_data_byte = '0;
  logic                      in_last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_found;
  logic [ADDR_BITS-1:0]      out_match_address;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_write_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int hits_checked;

  // Stimulus state
  logic                calm = 1'b0;
  logic [63:0]         pat_lo;
  logic [63:0]         pat_hi;
  logic [127:0]        pat_all;
  logic [15:0]         care_bits;
  logic [LEN_BITS-1:0] len_code;
  logic [63:0]         base_addr;
  logic [15:0]         new_care;
  logic [63:0]         new_base;
  logic [LEN_BITS-1:0] new_len;
  int                  elen;
  byte_t               img[256];
  int                  n;
  int                  pos;
  int                  kind;
  int                  flip;
  logic                tweak;
  int                  bytes_sent = 0;
  int                  images = 0;
  int                  setups = 0;
  int                  phase_bytes;

  always #5 clk = ~clk;

  wildcard_byte_pattern_search_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_write_data    (cfg_write_data)
  );

  byte_scan_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_write_data    (cfg_write_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked),
    .hits_checked      (hits_checked)
  );

  // Receiver back-pressure
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 31);

  // One image byte, with random idle cycles ahead of it
  task automatic send_byte(input byte_t data, input logic last);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (last) images++;
  endtask

  // Hold off until every pending result is out, plus the result register latency
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] data);
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= data;
    @(posedge clk);
  endtask

  // Full register setup; junk goes to the unused upper bits and a spare index
  task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] care, input logic [LEN_BITS-1:0] len,
                            input logic [63:0] base);
    write_reg(CFG_INDEX_BITS'($urandom_range(SPARE_FIRST, SPARE_LAST)), {$urandom, $urandom});
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {$urandom, 16'($urandom), care});
    write_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
    write_reg(REG_BASE_ADDRESS, base);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    pat_lo    = lo;
    pat_hi    = hi;
    pat_all   = {hi, lo};
    care_bits = care;
    len_code  = len;
    base_addr = base;
    elen      = (len == 0) ? 1 : ((len > PAT_BYTES) ? PAT_BYTES : int'(len));
    setups++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one-byte all-wildcard pattern, match on the last byte too
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);
    drain_results();

    // Four-byte pattern with address wrap: final position, short image, after a match
    load_setup(64'h0000_0000_EFBE_ADDE, '0, 16'h000F, LEN_BITS'(4), '1);
    send_byte(8'h11, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);

    // Registers changed in the middle of an image
    send_byte(8'h11, 1'b0);
    send_byte(8'hDE, 1'b0);
    drain_results();
    load_setup(64'h0000_0000_EFBE_ADDE, '0, 16'h0003, LEN_BITS'(2), '1);
    send_byte(8'hAD, 1'b1);
    drain_results();

    // Length zero behaves as one
    load_setup(64'h7E, '0, 16'h0001, '0, 64'h1000);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    drain_results();

    // Random phases, each under its own register setup
    for (int ph = 0; ph < 12; ph++) begin
      new_care = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
      new_len  = LEN_BITS'($urandom_range(1, PAT_BYTES));
      new_base = {$urandom, $urandom};
      case (ph)
        0: begin new_len = LEN_BITS'(PAT_BYTES); new_care = 16'hFFFF; new_base = '0; end
        1: new_len = LEN_BITS'(1);
        2: new_len = '0;
        3: begin new_len = '1; new_care = '0; new_base = '1; end
        4: new_len = LEN_BITS'(PAT_BYTES + 1);
        default: ;
      endcase
      if (ph == 5) load_setup('1, '1, new_care, new_len, new_base);
      else if (ph == 6) load_setup('0, '0, new_care, new_len, new_base);
      else load_setup({$urandom, $urandom}, {$urandom, $urandom}, new_care, new_len, new_base);
      calm = (ph == 4);
      phase_bytes = 0;
      while (phase_bytes < 90) begin
        kind = $urandom_range(99);
        n = ($urandom_range(19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        if (kind < 15 && elen > 1) n = $urandom_range(1, elen - 1);
        for (int i = 0; i < n; i++) img[i] = byte_t'($urandom);
        // Short image: a pattern prefix that can never complete
        if (n < elen) begin
          for (int k = 0; k < n; k++)
            if (care_bits[k]) img[k] = pat_all[8*k +: 8];
        end else if (kind >= 15 && kind < 85) begin
          pos = (kind < 30) ? n - elen : $urandom_range(0, n - elen);
          for (int k = 0; k < elen; k++)
            if (care_bits[k]) img[pos + k] = pat_all[8*k +: 8];
          // Near miss: one bit of the planted copy flipped
          if (kind >= 70) begin
            flip = $urandom_range(0, elen - 1);
            img[pos + flip] ^= byte_t'(1 << $urandom_range(7));
          end
        end
        tweak = ($urandom_range(39) == 0) && n > 2;
        for (int i = 0; i < n; i++) begin
          if (tweak && i == n / 2) begin
            drain_results();
            load_setup(pat_lo, pat_hi, 16'($urandom), len_code, base_addr);
          end
          send_byte(img[i], i == n - 1);
        end
        phase_bytes += n;
      end
      drain_results();
      calm = 1'b0;
    end

    drain_results();
    $display("Scanned %0d bytes in %0d images under %0d register setups.",
             bytes_sent, images, setups);
    $display("Checked %0d results, %0d of them matches.", results_checked, hits_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timeout: stimulus or results stopped moving");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
